// ===== rtl/rvc_pkg.sv =====
// Shared types and constants for the range Vigenere cipher block.
// Used by rvc_key_store and range_vigenere_cipher_core; depends on nothing else.
package rvc_pkg;

    localparam int KEY_DEPTH = 16;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);

    // configuration register indexes
    localparam logic [1:0] REG_RANGE_LOW    = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH   = 2'd1;
    localparam logic [1:0] REG_KEY_LENGTH   = 2'd2;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd3;

    localparam logic [7:0] RANGE_LOW_RST  = 8'd97;
    localparam logic [7:0] RANGE_HIGH_RST = 8'd122;
    localparam logic [4:0] KEY_LENGTH_RST = 5'd1;

    // command codes
    localparam logic CMD_KEY_WRITE = 1'b0;
    localparam logic CMD_PROCESS   = 1'b1;

    typedef struct packed {
        logic       command;
        logic [3:0] key_slot;
        logic [7:0] char_value;
        logic       first;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       shifted;
    } t_out_word;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] slot;
        logic [7:0]        data;
    } t_key_wr;

endpackage

// ===== rtl/rvc_key_store.sv =====
// Key byte store: one write port, one registered read port.
// Depends on rvc_pkg.
module rvc_key_store (
    input  logic                      i_clk,
    input  rvc_pkg::t_key_wr          i_wr,
    input  logic [rvc_pkg::KEY_AW-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);
    import rvc_pkg::*;

    logic [7:0] r_mem [KEY_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rvc_cmp_sub.sv =====
// Shared compare-and-subtract unit: y = (a >= b) ? a - b : a.
// Serves the remainder steps and the final wrap; depends on nothing.
module rvc_cmp_sub (
    input  logic [8:0] i_a,
    input  logic [8:0] i_b,
    output logic [8:0] o_y
);
    logic ge;

    always_comb begin
        ge  = (i_a >= i_b);
        o_y = ge ? (i_a - i_b) : i_a;
    end

endmodule

// ===== rtl/range_vigenere_cipher_core.sv =====
// Top level of the range Vigenere cipher: registers, sequencer, key position.
// Depends on rvc_pkg, rvc_key_store and rvc_cmp_sub.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A key write is stored on acceptance and gives no output word. A pass-through
// byte goes from the accept cycle to the output load; a shifted byte passes the
// accept cycle, one key read, eight restoring remainder steps through the shared
// compare-subtract unit, one sign fix, one wrap and one output load.
// Synchronous active-low reset restores control registers and the key position;
// the key store is not cleared. A stalled output word holds in its register;
// the next word is taken meanwhile and waits in the sequencer until it drains.
module range_vigenere_cipher_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rvc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rvc_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import rvc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [7:0]        r_low, r_high;
    logic [4:0]        r_key_len;
    logic              r_decrypt;
    logic [2:0]        r_state, n_state;
    logic [KEY_AW-1:0] r_pos, n_pos;
    logic [7:0]        r_c, n_c;
    logic [7:0]        r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [7:0]        r_rem, n_rem;
    logic [2:0]        r_cnt, n_cnt;
    logic [8:0]        r_t, n_t;
    t_out_word         r_res, n_res;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              in_accept;
    logic              pass;
    logic [4:0]        eff_len;
    logic [KEY_AW-1:0] pos_first, pos_use;
    logic [KEY_AW:0]   pos_inc;
    logic [8:0]        size;
    logic [8:0]        unit_a, unit_y;
    logic [7:0]        key_byte;
    logic [8:0]        diff;
    logic [7:0]        shift;
    logic [7:0]        offset;
    logic [9:0]        t_wide;
    t_key_wr           key_wr;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign size = {1'b0, r_high} - {1'b0, r_low} + 9'd1;

    always_comb begin
        if (r_key_len == 5'd0) begin
            eff_len = 5'd1;
        end else if (r_key_len > 5'(KEY_DEPTH)) begin
            eff_len = 5'(KEY_DEPTH);
        end else begin
            eff_len = r_key_len;
        end
    end

    // restart on first, then restart a position left stale by a shorter key
    assign pos_first = i_in_word.first ? '0 : r_pos;
    assign pos_use   = ({1'b0, pos_first} >= (KEY_AW+1)'(eff_len)) ? '0 : pos_first;
    assign pos_inc   = {1'b0, pos_use} + (KEY_AW+1)'(1);

    assign pass = (r_high <= r_low) || (i_in_word.char_value < r_low)
                  || (i_in_word.char_value > r_high);

    assign key_wr.en   = in_accept && (i_in_word.command == CMD_KEY_WRITE);
    assign key_wr.slot = i_in_word.key_slot[KEY_AW-1:0];
    assign key_wr.data = i_in_word.char_value;

    rvc_key_store u_key_store (
        .i_clk     (i_clk),
        .i_wr      (key_wr),
        .i_rd_addr (pos_use),
        .o_rd_data (key_byte)
    );

    assign unit_a = (r_state == ST_DIV) ? {r_rem, r_mag[7]} : r_t;

    rvc_cmp_sub u_cmp_sub (
        .i_a  (unit_a),
        .i_b  (size),
        .o_y  (unit_y)
    );

    assign diff   = {1'b0, key_byte} - {1'b0, r_low};
    assign shift  = (r_neg && (r_rem != 8'd0)) ? 8'(size - {1'b0, r_rem}) : r_rem;
    assign offset = r_c - r_low;
    assign t_wide = r_decrypt ? ({2'b00, offset} + {1'b0, size} - {2'b00, shift})
                              : ({2'b00, offset} + {2'b00, shift});

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_c         = r_c;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_t         = r_t;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_in_word.command == CMD_PROCESS)) begin
                    n_c = i_in_word.char_value;
                    if (pass) begin
                        n_pos          = pos_first;
                        n_res.out_char = i_in_word.char_value;
                        n_res.shifted  = 1'b0;
                        n_state        = ST_DONE;
                    end else begin
                        n_pos   = (pos_inc == (KEY_AW+1)'(eff_len)) ? '0
                                                                    : pos_inc[KEY_AW-1:0];
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // remainder of |key - low|, sign fixed afterwards
                n_neg   = diff[8];
                n_mag   = diff[8] ? 8'(-diff) : diff[7:0];
                n_rem   = 8'd0;
                n_cnt   = 3'd7;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = unit_y[7:0];
                n_mag = {r_mag[6:0], 1'b0};
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                n_t     = t_wide[8:0];
                n_state = ST_FINAL;
            end
            ST_FINAL: begin
                n_res.out_char = r_low + unit_y[7:0];
                n_res.shifted  = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_low       <= RANGE_LOW_RST;
            r_high      <= RANGE_HIGH_RST;
            r_key_len   <= KEY_LENGTH_RST;
            r_decrypt   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANGE_LOW:    r_low     <= i_cfg_data;
                    REG_RANGE_HIGH:   r_high    <= i_cfg_data;
                    REG_KEY_LENGTH:   r_key_len <= i_cfg_data[4:0];
                    REG_DECRYPT_MODE: r_decrypt <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_t   <= n_t;
        r_res <= n_res;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_shifted_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.shifted) |-> (r_out.out_char >= r_low && r_out.out_char <= r_high))
        else $error("shifted word outside the character range");

    a_rem_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_rem} < size))
        else $error("partial remainder not below range size");

    a_key_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.command == CMD_KEY_WRITE && !r_out_valid) |=> !r_out_valid)
        else $error("key write produced an output word");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.command == CMD_PROCESS) |=> !o_in_ready)
        else $error("sequencer took a word while busy");
`endif

endmodule
